>>> rtl/fkhp_pkg.sv
// Package for the fan start-kick and hysteresis PWM block.
// Holds field widths, reset values, register indexes and shared struct types.
// No dependencies.
`default_nettype none

package fkhp_pkg;

  localparam int unsigned PCT_W      = 7;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned KICK_W     = 16;
  localparam int unsigned DUTY_W     = 8;
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned TBL_N      = 2 ** PCT_W;

  localparam int unsigned PWM_BITS_DEF = 8;

  localparam logic [PCT_W-1:0] PCT_MAX = PCT_W'(100);

  // user 1..100 maps to PWM 27..100: pwm = (PWM_BASE + (u - 1) * PWM_STEP) / PWM_SPAN
  localparam int unsigned PWM_MIN_PCT = 27;
  localparam int unsigned PWM_STEP    = 73;
  localparam int unsigned PWM_SPAN    = 99;
  localparam int unsigned PWM_BASE    = PWM_MIN_PCT * PWM_SPAN;

  localparam logic [PCT_W-1:0]  START_PCT_RST = PCT_W'(30);
  localparam logic [PCT_W-1:0]  STOP_PCT_RST  = PCT_W'(20);
  localparam logic [KICK_W-1:0] KICK_MS_RST   = KICK_W'(2000);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_START_PWM = 4'd0,
    CFG_STOP_PWM  = 4'd1,
    CFG_KICK_TIME = 4'd2,
    CFG_INVERT    = 4'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [PCT_W-1:0]  start_pwm_pct;
    logic [PCT_W-1:0]  stop_pwm_pct;
    logic [KICK_W-1:0] kick_time_ms;
    logic              invert_output;
  } cfg_t;

  typedef struct packed {
    logic [PCT_W-1:0] actual_pct;
    logic             fan_on;
    logic             kick_on;
  } ctrl_res_t;

endpackage

`default_nettype wire

>>> rtl/fkhp_intf.sv
// Channel interfaces: control item input, result output and register writes.
// Depends on fkhp_pkg.
`default_nettype none

interface fkhp_item_if import fkhp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PCT_W-1:0]  requested_pct;
  logic [TIME_W-1:0] now_ms;

  modport source (output valid, output requested_pct, output now_ms, input ready);
  modport sink   (input valid, input requested_pct, input now_ms, output ready);
endinterface

interface fkhp_res_if import fkhp_pkg::*;;
  logic              valid;
  logic              ready;
  logic [PCT_W-1:0]  actual_pct;
  logic [DUTY_W-1:0] duty_value;
  logic              fan_on;
  logic              kick_on;

  modport source (output valid, output actual_pct, output duty_value, output fan_on,
                  output kick_on, input ready);
  modport sink   (input valid, input actual_pct, input duty_value, input fan_on,
                  input kick_on, output ready);
endinterface

interface fkhp_cfg_if import fkhp_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

>>> rtl/fkhp_cfg_regs.sv
// Configuration register file: start/stop levels, kick time and output polarity.
// Depends on fkhp_pkg and fkhp_cfg_if.
`default_nettype none

module fkhp_cfg_regs import fkhp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  fkhp_cfg_if.sink   cfg_i,
  output cfg_t       cfg_o
);

  cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_START_PWM: cfg_d.start_pwm_pct = cfg_i.data[PCT_W-1:0];
        CFG_STOP_PWM:  cfg_d.stop_pwm_pct  = cfg_i.data[PCT_W-1:0];
        CFG_KICK_TIME: cfg_d.kick_time_ms  = cfg_i.data[KICK_W-1:0];
        CFG_INVERT:    cfg_d.invert_output = cfg_i.data[0];
        default:       cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.start_pwm_pct <= START_PCT_RST;
      cfg_q.stop_pwm_pct  <= STOP_PCT_RST;
      cfg_q.kick_time_ms  <= KICK_MS_RST;
      cfg_q.invert_output <= 1'b0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

>>> rtl/fkhp_conv.sv
// Percent and duty conversion tables, built at elaboration from exact rationals.
// Depends on fkhp_pkg.
`default_nettype none

module fkhp_conv import fkhp_pkg::*; #(
  parameter int unsigned PwmBits = PWM_BITS_DEF
) (
  input  logic [PCT_W-1:0]  req_pct_i,
  input  logic [PCT_W-1:0]  start_pct_i,
  input  logic [PCT_W-1:0]  applied_pct_i,
  input  logic              invert_i,
  output logic [PCT_W-1:0]  req_pwm_o,
  output logic [PCT_W-1:0]  kick_pct_o,
  output logic [DUTY_W-1:0] duty_o
);

  localparam longint unsigned DutyMax = (64'd1 << PwmBits) - 64'd1;

  logic [PCT_W-1:0]  u2p   [TBL_N];
  logic [PCT_W-1:0]  p2u   [TBL_N];
  logic [DUTY_W-1:0] dnorm [TBL_N];
  logic [DUTY_W-1:0] dinv  [TBL_N];

  for (genvar g = 0; g < TBL_N; g++) begin : g_tbl
    localparam longint unsigned U   = (g > 100) ? 100 : g;
    localparam longint unsigned N   = (U == 0) ? 0 : PWM_BASE + (U - 1) * PWM_STEP;
    localparam longint unsigned Pwm = (U == 0) ? 0 : (2 * N + 99) / 198;
    localparam longint unsigned Num = (g < PWM_MIN_PCT) ? 0 :
                                      PWM_STEP + (g - PWM_MIN_PCT) * PWM_SPAN;
    localparam longint unsigned Usr = (g == 0) ? 0 :
                                      (g < PWM_MIN_PCT) ? 1 :
                                      (Num >= 7300) ? 100 : (2 * Num + 73) / 146;
    localparam longint unsigned Nrm = (U == 0) ? 0 : (2 * N * DutyMax + 9900) / 19800;
    localparam longint unsigned Inv = (U == 0) ? 0 :
                                      DutyMax - ((N / 99) * DutyMax) / 100;
    assign u2p[g]   = PCT_W'(Pwm);
    assign p2u[g]   = PCT_W'(Usr);
    assign dnorm[g] = DUTY_W'(Nrm);
    assign dinv[g]  = DUTY_W'(Inv);
  end

  assign req_pwm_o  = u2p[req_pct_i];
  assign kick_pct_o = p2u[start_pct_i];
  assign duty_o     = invert_i ? dinv[applied_pct_i] : dnorm[applied_pct_i];

endmodule

`default_nettype wire

>>> rtl/fkhp_ctrl.sv
// Run/kick state and hysteresis decision for one control update.
// Depends on fkhp_pkg.
`default_nettype none

module fkhp_ctrl import fkhp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              advance_i,
  input  logic [PCT_W-1:0]  req_pct_i,
  input  logic [TIME_W-1:0] now_ms_i,
  input  logic [PCT_W-1:0]  req_pwm_i,
  input  logic [PCT_W-1:0]  kick_pct_i,
  input  cfg_t              cfg_i,
  output ctrl_res_t         res_o
);

  logic              run_q, run_d;
  logic              kick_q, kick_d;
  logic [TIME_W-1:0] kick_t0_q, kick_t0_d;
  logic              below_stop;
  logic              expired;
  logic [TIME_W-1:0] elapsed;
  logic [PCT_W-1:0]  applied;

  assign below_stop = (req_pct_i == '0) || (req_pwm_i < cfg_i.stop_pwm_pct);
  assign elapsed    = now_ms_i - kick_t0_q;
  assign expired    = elapsed >= {{(TIME_W-KICK_W){1'b0}}, cfg_i.kick_time_ms};

  always_comb begin
    run_d     = run_q;
    kick_d    = kick_q;
    kick_t0_d = kick_t0_q;
    applied   = '0;
    if (kick_q) begin
      if (expired) begin
        kick_d = 1'b0;
        if (below_stop) begin
          run_d = 1'b0;
        end else begin
          applied = req_pct_i;
        end
      end else begin
        applied = kick_pct_i;
      end
    end else if (!run_q) begin
      if ((req_pct_i != '0) && (req_pwm_i >= cfg_i.start_pwm_pct)) begin
        run_d     = 1'b1;
        kick_d    = 1'b1;
        kick_t0_d = now_ms_i;
        applied   = kick_pct_i;
      end
    end else if (below_stop) begin
      run_d = 1'b0;
    end else begin
      applied = req_pct_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q     <= 1'b0;
      kick_q    <= 1'b0;
      kick_t0_q <= '0;
    end else if (advance_i) begin
      run_q     <= run_d;
      kick_q    <= kick_d;
      kick_t0_q <= kick_t0_d;
    end
  end

  assign res_o.actual_pct = applied;
  assign res_o.fan_on     = run_d;
  assign res_o.kick_on    = kick_d;

endmodule

`default_nettype wire

>>> rtl/fan_kick_hysteresis_pwm.sv
// Top level of the fan start-kick and hysteresis PWM controller.
// Depends on fkhp_pkg, the fkhp interfaces, fkhp_cfg_regs, fkhp_conv and fkhp_ctrl.
//
// Usage:
//   in_i   takes one control update per transfer: requested_pct and now_ms.
//   out_o  gives one result per update: actual_pct, duty_value, fan_on, kick_on.
//   cfg_i  writes start/stop levels, kick time and polarity by register index;
//          always ready; user must write it with no update in flight (unchecked).
// Path: an update goes from in_i into the input register, then its result into
//   the result register that drives out_o.
// Throughput: one update per cycle unless out_o stalls; input and result registers
//   advance independently, so an update is taken while a finished result waits.
// Stall: while out_o is not taken and the input register is full, in_i.ready is
//   low; the result is held on out_o.
// Reset: fan off, no kick, kick start time zero; registers return to start 30%,
//   stop 20%, kick time 2000 ms, normal polarity. Both stages come up empty.
`default_nettype none

module fan_kick_hysteresis_pwm import fkhp_pkg::*; #(
  parameter int unsigned PwmBits = PWM_BITS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  fkhp_cfg_if.sink    cfg_i,
  fkhp_item_if.sink   in_i,
  fkhp_res_if.source  out_o
);

  cfg_t              cfg;
  ctrl_res_t         ctrl_res;

  logic              in_valid_q;
  logic [PCT_W-1:0]  req_q;
  logic [TIME_W-1:0] now_q;
  logic              out_valid_q;
  logic [PCT_W-1:0]  act_q;
  logic [DUTY_W-1:0] duty_q;
  logic              fan_q;
  logic              kick_q;

  logic              out_free;
  logic              advance;
  logic [PCT_W-1:0]  req_sat;
  logic [PCT_W-1:0]  req_pwm;
  logic [PCT_W-1:0]  kick_pct;
  logic [DUTY_W-1:0] duty;

  assign out_free   = !out_valid_q || out_o.ready;
  assign advance    = in_valid_q && out_free;
  assign in_i.ready = !in_valid_q || out_free;
  assign req_sat    = (req_q > PCT_MAX) ? PCT_MAX : req_q;

  fkhp_cfg_regs u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  fkhp_conv #(
    .PwmBits (PwmBits)
  ) u_conv (
    .req_pct_i     (req_sat),
    .start_pct_i   (cfg.start_pwm_pct),
    .applied_pct_i (ctrl_res.actual_pct),
    .invert_i      (cfg.invert_output),
    .req_pwm_o     (req_pwm),
    .kick_pct_o    (kick_pct),
    .duty_o        (duty)
  );

  fkhp_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .advance_i  (advance),
    .req_pct_i  (req_sat),
    .now_ms_i   (now_q),
    .req_pwm_i  (req_pwm),
    .kick_pct_i (kick_pct),
    .cfg_i      (cfg),
    .res_o      (ctrl_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_valid_q <= in_i.valid;
      end
      if (out_free) begin
        out_valid_q <= in_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      req_q <= in_i.requested_pct;
      now_q <= in_i.now_ms;
    end
    if (advance) begin
      act_q  <= ctrl_res.actual_pct;
      duty_q <= duty;
      fan_q  <= ctrl_res.fan_on;
      kick_q <= ctrl_res.kick_on;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.actual_pct = act_q;
  assign out_o.duty_value = duty_q;
  assign out_o.fan_on     = fan_q;
  assign out_o.kick_on    = kick_q;

`ifndef NO_ASSERTIONS
  a_kick_implies_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.kick_on) |-> out_o.fan_on)
    else $error("kick reported while fan is off");

  a_off_means_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && !out_o.fan_on) |-> (out_o.actual_pct == '0))
    else $error("nonzero speed with fan off");

  a_zero_duty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && (out_o.actual_pct == '0)) |-> (out_o.duty_value == '0))
    else $error("nonzero duty at zero speed");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while both stages are full");
`endif

endmodule

`default_nettype wire
